// File: hdl/pdu_pkg.sv
// Shared types, register indexes and constants for the packed-decimal unpacker.
// No dependencies; every other file of the block but the checker imports this package.
package pdu_pkg;

	localparam int DIGIT_W        = 4;
	localparam int BYTE_W         = 8;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 4;
	localparam int MAX_DIGITS_DEF = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_HIGH_NIBBLE = 2'd2;

	localparam logic [DIGIT_W-1:0] DIGIT_COUNT_RESET = 4'd15;
	localparam logic [DIGIT_W-1:0] SIGN_NEG_B        = 4'hB;
	localparam logic [DIGIT_W-1:0] SIGN_NEG_D        = 4'hD;
	localparam logic [DIGIT_W-1:0] NIBBLE_MAX        = 4'hF;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit_count;
		logic               signed_mode;
		logic               start_high_nibble;
	} pdu_cfg_t;

	typedef struct packed {
		logic sign_pending;
		logic is_negative;
		logic in_number;
	} pdu_flags_t;

	// Bits needed for the largest magnitude of n digit nibbles, every one at 15.
	function automatic int acc_width(input int n);
		longint unsigned v;
		int bits;
		v = 0;
		bits = 0;
		for (int i = 0; i < n; i++) begin
			v = v * 10 + longint'(NIBBLE_MAX);
		end
		for (int i = 0; i < 64; i++) begin
			if (v != 0) begin
				bits++;
				v = v >> 1;
			end
		end
		return bits;
	endfunction

endpackage

// File: hdl/pdu_cfg.sv
// Configuration registers of the packed-decimal unpacker.
// Depends on pdu_pkg for register indexes, reset values and the config struct.
module pdu_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pdu_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pdu_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pdu_pkg::pdu_cfg_t                  cfg
);
	import pdu_pkg::*;

	pdu_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_count       <= DIGIT_COUNT_RESET;
			cfg_q.signed_mode       <= 1'b1;
			cfg_q.start_high_nibble <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DIGIT_COUNT:       cfg_q.digit_count       <= cfg_data[DIGIT_W-1:0];
				REG_SIGNED_MODE:       cfg_q.signed_mode       <= cfg_data[0];
				REG_START_HIGH_NIBBLE: cfg_q.start_high_nibble <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/pdu_step.sv
// Single-pass datapath: takes one byte through the sign and digit steps of both nibbles.
// Depends on pdu_pkg for the config and flag structs and the sign codes.
module pdu_step #(
	parameter int MAX_DIGITS = pdu_pkg::MAX_DIGITS_DEF,
	parameter int ACC_W      = pdu_pkg::acc_width(MAX_DIGITS),
	parameter int CNT_W      = $clog2(MAX_DIGITS + 1),
	parameter int VALUE_W    = ACC_W + 1
) (
	input  pdu_pkg::pdu_cfg_t                cfg,
	input  logic [pdu_pkg::BYTE_W-1:0]       data_byte,
	input  logic [ACC_W-1:0]                 acc,
	input  logic [CNT_W-1:0]                 left,
	input  pdu_pkg::pdu_flags_t              flags,
	output logic [ACC_W-1:0]                 acc_next,
	output logic [CNT_W-1:0]                 left_next,
	output pdu_pkg::pdu_flags_t              flags_next,
	output logic                             emit,
	output logic signed [VALUE_W-1:0]        result
);
	import pdu_pkg::*;

	logic [DIGIT_W-1:0] hi;
	logic [DIGIT_W-1:0] lo;
	logic [CNT_W-1:0]   eff;
	logic               start;
	logic               skip_hi;
	logic [ACC_W-1:0]   acc_a, acc_b, acc_c;
	logic [CNT_W-1:0]   left_a, left_b, left_c;
	logic               sp_a, sp_b, sp_c;
	logic               neg_a, neg_b, neg_c;
	logic               done_h, done_l;
	logic [VALUE_W-1:0] mag;

	assign hi = data_byte[BYTE_W-1:DIGIT_W];
	assign lo = data_byte[DIGIT_W-1:0];

	always_comb begin
		if (cfg.digit_count == '0) begin
			eff = CNT_W'(1);
		end else if (int'(cfg.digit_count) > MAX_DIGITS) begin
			eff = CNT_W'(MAX_DIGITS);
		end else begin
			eff = CNT_W'(cfg.digit_count);
		end
	end

	always_comb begin
		start   = !flags.in_number;
		skip_hi = start && !cfg.start_high_nibble;
		acc_a   = start ? '0 : acc;
		left_a  = start ? eff : left;
		sp_a    = start ? cfg.signed_mode : flags.sign_pending;
		neg_a   = start ? 1'b0 : flags.is_negative;

		acc_b  = acc_a;
		left_b = left_a;
		sp_b   = sp_a;
		neg_b  = neg_a;
		done_h = 1'b0;
		if (!skip_hi) begin
			if (sp_a) begin
				neg_b = (hi == SIGN_NEG_B) || (hi == SIGN_NEG_D);
				sp_b  = 1'b0;
			end else begin
				acc_b  = (acc_a << 3) + (acc_a << 1) + ACC_W'(hi);
				left_b = (left_a != '0) ? left_a - CNT_W'(1) : left_a;
				done_h = (left_b == '0);
			end
		end

		acc_c  = acc_b;
		left_c = left_b;
		sp_c   = sp_b;
		neg_c  = neg_b;
		done_l = 1'b0;
		if (!done_h) begin
			if (sp_b) begin
				neg_c = (lo == SIGN_NEG_B) || (lo == SIGN_NEG_D);
				sp_c  = 1'b0;
			end else begin
				acc_c  = (acc_b << 3) + (acc_b << 1) + ACC_W'(lo);
				left_c = (left_b != '0) ? left_b - CNT_W'(1) : left_b;
				done_l = (left_c == '0);
			end
		end

		emit                    = done_h || done_l;
		acc_next                = acc_c;
		left_next               = left_c;
		flags_next.sign_pending = sp_c;
		flags_next.is_negative  = neg_c;
		flags_next.in_number    = !emit;
		mag                     = VALUE_W'(acc_c);
		result                  = neg_c ? -mag : mag;
	end

endmodule

// File: hdl/packed_decimal_unpacker.sv
// Top level of the packed-decimal unpacker: input register, number state and result register.
// Depends on pdu_pkg, pdu_cfg and pdu_step.
//
// The block takes one byte in every cycle unless it stalls the source and returns each packed
// number as a signed binary value once the byte holding its last digit has passed the input
// register and the result register. Both nibbles of a byte go through one pass of the step
// logic (two multiply-by-ten adds) between the input and result registers, so the sustained
// rate is one byte per cycle without stall. A result waiting under stall still lets one more
// byte in; stall goes back to the source only while that byte and the result are both held.
module packed_decimal_unpacker #(
	parameter int MAX_DIGITS = pdu_pkg::MAX_DIGITS_DEF,
	localparam int ACC_W     = pdu_pkg::acc_width(MAX_DIGITS),
	localparam int VALUE_W   = ACC_W + 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pdu_pkg::BYTE_W-1:0]        data_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [VALUE_W-1:0]         value,
	input  logic                              cfg_write,
	input  logic [pdu_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pdu_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pdu_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	pdu_cfg_t              cfg;
	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic                  advance;
	logic [ACC_W-1:0]      acc_q;
	logic [CNT_W-1:0]      left_q;
	pdu_flags_t            flags_q;
	logic [ACC_W-1:0]      acc_next;
	logic [CNT_W-1:0]      left_next;
	pdu_flags_t            flags_next;
	logic                  emit;
	logic signed [VALUE_W-1:0] result;
	logic                  out_valid_q;
	logic signed [VALUE_W-1:0] value_q;

	pdu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdu_step #(
		.MAX_DIGITS (MAX_DIGITS),
		.ACC_W      (ACC_W),
		.CNT_W      (CNT_W),
		.VALUE_W    (VALUE_W)
	) u_step (
		.cfg        (cfg),
		.data_byte  (byte_s1),
		.acc        (acc_q),
		.left       (left_q),
		.flags      (flags_q),
		.acc_next   (acc_next),
		.left_next  (left_next),
		.flags_next (flags_next),
		.emit       (emit),
		.result     (result)
	);

	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign advance  = valid_s1 && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			left_q  <= '0;
			flags_q <= '0;
		end else if (advance) begin
			acc_q   <= acc_next;
			left_q  <= left_next;
			flags_q <= flags_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

// File: hdl/pdu_checker.sv
// Port-level checker for the packed-decimal unpacker, with the bind that attaches it.
// Depends only on the top level's ports.
module pdu_checker #(
	parameter int VALUE_W = 52
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [VALUE_W-1:0] value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value))
		else $error("Stalled result item changed or vanished.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled without a stalled result item.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("Result item appeared without an input item two cycles before.");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("Input stalled while the result side was empty.");

endmodule

bind packed_decimal_unpacker pdu_checker #(.VALUE_W(VALUE_W)) u_pdu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value     (value)
);

// File: verif/tb_packed_decimal_unpacker.sv
// Self-checking testbench for the packed-decimal unpacker: directed and random byte streams
// under random idling (off in the last phase), each number predicted in the bench and checked
// as it leaves. Depends on pdu_pkg and packed_decimal_unpacker.
`timescale 1ns / 1ps

module tb_packed_decimal_unpacker;
	import pdu_pkg::*;

	localparam int MAX_DIGITS = MAX_DIGITS_DEF;
	localparam int VALUE_W = 52;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_BYTES = 56;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [DIGIT_W-1:0] SIGN_POS_C = 4'hC;

	typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_NINE} digit_fill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [BYTE_W-1:0] data_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VALUE_W-1:0] value;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [BYTE_W-1:0] byte_queue[$];
	logic signed [VALUE_W-1:0] expected_values[$];
	int fail_count = 0;
	bit idle_on = 1'b1;
	bit long_hold_start = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;

	// Bench copy of the registers and of the number in progress.
	logic [DIGIT_W-1:0] model_digit_count = DIGIT_COUNT_RESET;
	bit model_signed = 1'b1;
	bit model_high = 1'b1;
	logic [63:0] num_magnitude = '0;
	int num_digits_left = 0;
	bit num_sign_next = 1'b0;
	bit num_negative = 1'b0;
	bit num_active = 1'b0;

	// Register values the stimulus is built for.
	logic [DIGIT_W-1:0] gen_digit_count = DIGIT_COUNT_RESET;
	bit gen_signed = 1'b1;
	bit gen_high = 1'b1;

	packed_decimal_unpacker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	task automatic unpack_byte(input logic [BYTE_W-1:0] b);
		int first;
		int k;
		logic [DIGIT_W-1:0] nib;
		logic [63:0] signed_value;
		first = 0;
		if (!num_active) begin
			num_active = 1'b1;
			num_magnitude = '0;
			num_digits_left = (model_digit_count == 0) ? 1 : int'(model_digit_count);
			if (num_digits_left > MAX_DIGITS) begin
				num_digits_left = MAX_DIGITS;
			end
			num_sign_next = model_signed;
			num_negative = 1'b0;
			first = model_high ? 0 : 1;
		end
		for (k = first; k < 2 && num_active; k++) begin
			nib = (k == 0) ? b[7:4] : b[3:0];
			if (num_sign_next) begin
				num_negative = (nib == SIGN_NEG_B || nib == SIGN_NEG_D);
				num_sign_next = 1'b0;
			end else begin
				num_magnitude = num_magnitude * 10 + 64'(nib);
				if (num_digits_left > 0) begin
					num_digits_left--;
				end
				if (num_digits_left == 0) begin
					signed_value = num_negative ? (64'd0 - num_magnitude) : num_magnitude;
					expected_values.push_back(signed_value[VALUE_W-1:0]);
					num_active = 1'b0;
				end
			end
		end
	endtask

	task automatic push_number(input logic [DIGIT_W-1:0] sign_nib, input digit_fill_t fill);
		logic [DIGIT_W-1:0] nibs[$];
		int count;
		count = (gen_digit_count == 0) ? 1 : int'(gen_digit_count);
		if (count > MAX_DIGITS) begin
			count = MAX_DIGITS;
		end
		if (!gen_high) begin
			nibs.push_back(4'($urandom));
		end
		if (gen_signed) begin
			nibs.push_back(sign_nib);
		end
		repeat (count) begin
			case (fill)
				FILL_MAX: nibs.push_back(NIBBLE_MAX);
				FILL_ZERO: nibs.push_back(4'd0);
				FILL_NINE: nibs.push_back(4'd9);
				default: nibs.push_back(($urandom_range(0, 6) == 0) ?
					4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9)));
			endcase
		end
		if (nibs.size() % 2 != 0) begin
			nibs.push_back(4'($urandom));
		end
		for (int i = 0; i < nibs.size(); i += 2) begin
			byte_queue.push_back({nibs[i], nibs[i+1]});
		end
	endtask

	function automatic logic [DIGIT_W-1:0] pick_sign();
		case ($urandom_range(0, 4))
			0: return SIGN_NEG_B;
			1: return SIGN_NEG_D;
			2: return SIGN_POS_C;
			3: return NIBBLE_MAX;
			default: return 4'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] digits,
			input logic [CFG_DATA_W-1:0] sgn, input logic [CFG_DATA_W-1:0] high);
		write_reg(REG_DIGIT_COUNT, digits);
		write_reg(REG_SIGNED_MODE, sgn);
		write_reg(REG_START_HIGH_NIBBLE, high);
		if ($urandom_range(0, 2) == 0) begin
			write_reg(REG_UNUSED, 4'($urandom));
		end
		gen_digit_count = digits;
		gen_signed = sgn[0];
		gen_high = high[0];
		@(negedge clk);
	endtask

	task automatic wait_drained();
		int cycles;
		cycles = 0;
		do begin
			@(negedge clk);
			cycles++;
		end while ((byte_queue.size() != 0 || in_valid || expected_values.size() != 0)
			&& cycles < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			tx_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (tx_gap != 0) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				tx_gap <= $urandom_range(0, 11);
			end else if (byte_queue.size() != 0) begin
				in_valid <= 1'b1;
				data_byte <= byte_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap <= 0;
			rx_hold <= 0;
		end else if (long_hold_start) begin
			out_stall <= 1'b1;
			rx_hold <= LONG_HOLD_CYCLES;
		end else if (rx_hold != 0) begin
			out_stall <= 1'b1;
			rx_hold <= rx_hold - 1;
		end else if (rx_gap != 0) begin
			out_stall <= 1'b1;
			rx_gap <= rx_gap - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			rx_gap <= $urandom_range(0, 11);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					REG_DIGIT_COUNT: model_digit_count = cfg_data[DIGIT_W-1:0];
					REG_SIGNED_MODE: model_signed = cfg_data[0];
					REG_START_HIGH_NIBBLE: model_high = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					note_failure($sformatf("unexpected value %0d", value));
				end else if (value !== expected_values[0]) begin
					note_failure($sformatf("value mismatch: expected %0d, got %0d",
						expected_values[0], value));
					void'(expected_values.pop_front());
				end else begin
					void'(expected_values.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				unpack_byte(data_byte);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int phase_start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: fifteen digits, signed, starting in the high nibble.
		push_number(SIGN_POS_C, FILL_MAX);
		push_number(SIGN_NEG_D, FILL_MAX);
		push_number(SIGN_NEG_B, FILL_ZERO);
		wait_drained();

		// A digit count of zero acts as one; unsigned numbers starting in the low nibble.
		apply_setting(4'd0, 4'd0, 4'd0);
		byte_queue.push_back(8'h00);
		byte_queue.push_back(8'hFF);
		byte_queue.push_back(8'h09);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_setting(4'd15, 4'd1, 4'd0);
				1: apply_setting(4'd1, 4'd0, 4'd1);
				3: apply_setting(4'd2, 4'd0, 4'd1);
				default: apply_setting(4'($urandom), 4'($urandom), 4'($urandom));
			endcase
			if (p == RANDOM_PHASES - 1) begin
				idle_on = 1'b0;
			end
			phase_start = byte_queue.size();
			while (byte_queue.size() - phase_start <
					((p == 3) ? 2 * PHASE_BYTES : PHASE_BYTES)) begin
				if ($urandom_range(0, 4) == 0) begin
					byte_queue.push_back(8'($urandom));
				end else begin
					push_number(pick_sign(), ($urandom_range(0, 9) == 0) ? FILL_MAX : FILL_RANDOM);
				end
			end
			if (p == 3) begin
				long_hold_start = 1'b1;
				@(negedge clk);
				long_hold_start = 1'b0;
			end
			wait_drained();
		end

		if (expected_values.size() != 0) begin
			note_failure($sformatf("%0d values never arrived", expected_values.size()));
		end
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
